// ===== rtl/bqeq_pkg.sv =====
// Shared types and constants for the biquad cascade equalizer with peak limiter.
// Depends on nothing; imported by the top level.
`default_nettype none
package bqeq_pkg;

  // Default sizing
  localparam int NUM_BANDS_DEF    = 10;
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int COEFF_BITS_DEF   = 32;

  // Fixed field widths
  localparam int SIG_W  = 48;   // internal signal, Q31.16
  localparam int SMP_W  = 24;   // port samples
  localparam int GAIN_W = 24;   // gains and smoothing factors
  localparam int DIG_W  = 17;   // multiplier digit, 16 bits plus sign
  localparam int CFG_W  = 24;   // widest configuration register

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd8388608;
  localparam logic [GAIN_W-1:0] UNITY_PRE  = 24'd1048576;
  localparam logic [22:0]       CEIL_16    = 23'd32760;
  localparam logic [22:0]       CEIL_24    = 23'd8386560;
  localparam int                COEF_SLOTS = 5;
  localparam int                DIV_STEPS  = 24;

  // Input commands
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BYPASS   = 3'd0,
    REG_BAND_EN  = 3'd1,
    REG_PREAMP   = 3'd2,
    REG_ATTACK   = 3'd3,
    REG_RELEASE  = 3'd4,
    REG_WIDE     = 3'd5,
    REG_CHANNELS = 3'd6
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_PRE,
    S_PRE_END,
    S_BAND_SEL,
    S_TERM_RD,
    S_TERM_MUL,
    S_BQ_END,
    S_WB,
    S_CH_END,
    S_LIM,
    S_DIV,
    S_SM1,
    S_SM2,
    S_SM_END,
    S_OUT,
    S_OUT_END,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/biquad_cascade_eq_limiter_top.sv =====
// Sequence: a coefficient load is taken while idle. A processed frame runs per channel the
// preamp and then each enabled band of the cascade, then the limiter (a bit-serial gain divide
// when the peak is over the ceiling, then gain smoothing), output scaling per channel, and emit.
// One frame at a time; the shared 49x17 multiplier (three digit passes per product) and the
// single-port history memory bound the frame rate. Bypassed frames skip the datapath.
// Reset: synchronous; history reads as zero, limiter gain is unity, coefficients undefined.
`default_nettype none
module biquad_cascade_eq_limiter_top
  import bqeq_pkg::*;
#(
  parameter int NUM_BANDS    = bqeq_pkg::NUM_BANDS_DEF,
  parameter int NUM_CHANNELS = bqeq_pkg::NUM_CHANNELS_DEF,
  parameter int COEFF_BITS   = bqeq_pkg::COEFF_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [2:0]                       cfg_index,
  input  wire logic [bqeq_pkg::CFG_W-1:0]       cfg_data,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             command,
  input  wire logic signed [bqeq_pkg::SMP_W-1:0] left_sample,
  input  wire logic signed [bqeq_pkg::SMP_W-1:0] right_sample,
  input  wire logic [3:0]                       coeff_band,
  input  wire logic [2:0]                       coeff_slot,
  input  wire logic signed [31:0]               coeff_value,
  // output channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [bqeq_pkg::SMP_W-1:0]     left_out,
  output logic signed [bqeq_pkg::SMP_W-1:0]     right_out,
  output logic [bqeq_pkg::GAIN_W-1:0]           gain_now
);

  localparam int A_W   = ((COEFF_BITS > SIG_W) ? COEFF_BITS : SIG_W) + 1;
  localparam int P_W   = A_W + DIG_W;
  localparam int ACC_W = A_W + SIG_W + 4;
  localparam int CFRAC = COEFF_BITS - 4;
  localparam int NCOEF = NUM_BANDS * COEF_SLOTS;
  localparam int CA_W  = $clog2(NCOEF);
  localparam int HD    = NUM_BANDS * NUM_CHANNELS * 4;
  localparam int HA_W  = $clog2(HD);
  localparam int BW    = $clog2(NUM_BANDS + 1);
  localparam int SH_L  = (COEFF_BITS >= 32) ? COEFF_BITS - 32 : 0;
  localparam int SH_R  = (COEFF_BITS < 32) ? 32 - COEFF_BITS : 0;
  localparam logic [31:0] BAND_MASK = (NUM_BANDS >= 32) ? 32'hFFFFFFFF
                                                        : 32'((64'd1 << NUM_BANDS) - 64'd1);

  // configuration registers
  logic                 bypass;
  logic [9:0]           band_enable;
  logic [GAIN_W-1:0]    preamp_gain;
  logic [GAIN_W-1:0]    atk_factor;
  logic [GAIN_W-1:0]    rel_factor;
  logic                 wide_samples;
  logic [1:0]           channel_count;

  // control and datapath state
  state_t               state, state_next;
  logic                 last_wide;
  logic [1:0]           nch;
  logic                 ch;
  logic [BW-1:0]        band;
  logic [2:0]           term;
  logic [1:0]           dig;
  logic [1:0]           wk;
  logic [4:0]           dcnt;
  logic signed [ACC_W-1:0] acc;
  logic signed [SMP_W-1:0] xin0, xin1;
  logic signed [SMP_W-1:0] ys0, ys1;
  logic signed [SIG_W-1:0] s, y, h0_old, h2_old, smp0, smp1;
  logic [SIG_W-1:0]     peak;
  logic [61:0]          rem;
  logic [70:0]          dsh;
  logic [23:0]          quo;
  logic [GAIN_W-1:0]    target;
  logic [GAIN_W-1:0]    gain;
  logic [HD-1:0]        hvalid;

  // memories
  logic signed [COEFF_BITS-1:0] coef_mem [NCOEF];
  logic signed [SIG_W-1:0]      hist_mem [HD];
  logic signed [COEFF_BITS-1:0] coef_q;
  logic signed [SIG_W-1:0]      hist_q;
  logic                         hv_q;

  // derived values
  logic [31:0]          en_ext;
  logic [1:0]           nch_cfg;
  logic                 active;
  logic                 in_acc;
  logic                 coef_ok;
  logic [CA_W-1:0]      coef_waddr, coef_raddr;
  logic signed [SIG_W-1:0] cv48, cv_scaled;
  logic [HA_W-1:0]      hbase, hist_raddr, hist_waddr;
  logic signed [SIG_W-1:0] hist_v;
  logic signed [SIG_W-1:0] hist_wdata;
  logic                 hist_we;
  logic                 emit_go;
  logic [GAIN_W-1:0]    csel;
  logic [24:0]          cmpl;
  logic signed [SMP_W-1:0] xin_ch;
  logic signed [SIG_W-1:0] smp_ch;
  logic signed [A_W-1:0]   op_a;
  logic signed [SIG_W-1:0] op_x;
  logic                 op_sub;
  logic signed [DIG_W-1:0] dsel;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] shifted, acc_sum;
  logic signed [ACC_W-1:0] bq_shr, out_shr, hi_lim, lo_lim;
  logic signed [SIG_W-1:0] bq_sat;
  logic signed [SMP_W-1:0] out_clamp;
  logic [SIG_W-1:0]     s_abs;
  logic [SIG_W-1:0]     ceil_q16;
  logic                 div_geq;
  logic [ACC_W-SIG_W:0] bq_top;

  assign en_ext  = {22'd0, band_enable};
  assign nch_cfg = (int'(channel_count) > NUM_CHANNELS) ? 2'(NUM_CHANNELS) : channel_count;
  assign active  = !bypass && ((en_ext & BAND_MASK) != 32'd0 || preamp_gain != UNITY_PRE);
  assign in_acc  = in_valid && !in_stall;
  assign coef_ok = (int'(coeff_band) < NUM_BANDS) && (int'(coeff_slot) < COEF_SLOTS);
  assign coef_waddr = CA_W'(int'(coeff_band) * COEF_SLOTS + int'(coeff_slot));
  assign coef_raddr = CA_W'(int'(band) * COEF_SLOTS + int'(term));
  assign cv48       = SIG_W'(coeff_value);
  assign cv_scaled  = (COEFF_BITS >= 32) ? (cv48 <<< SH_L) : (cv48 >>> SH_R);
  assign hbase      = HA_W'((int'(band) * NUM_CHANNELS + int'(ch)) * 4);
  assign hist_raddr = hbase + HA_W'(term - 3'd1);
  assign hist_waddr = hbase + HA_W'(wk);
  assign hist_v     = hv_q ? hist_q : '0;
  assign xin_ch     = ch ? xin1 : xin0;
  assign smp_ch     = ch ? smp1 : smp0;
  assign csel       = (target < gain) ? atk_factor : rel_factor;
  assign cmpl       = 25'h1000000 - {1'b0, csel};
  assign emit_go    = !out_valid || !out_stall;
  assign s_abs      = s[SIG_W-1] ? SIG_W'(-s) : s;
  assign ceil_q16   = SIG_W'({(wide_samples ? CEIL_24 : CEIL_16), 16'd0});
  assign div_geq    = {9'd0, rem} >= dsh;

  // history write data by step
  always_comb begin
    case (wk)
      2'd0:    hist_wdata = s;
      2'd1:    hist_wdata = h0_old;
      2'd2:    hist_wdata = y;
      default: hist_wdata = h2_old;
    endcase
  end

  // multiplier operand select
  always_comb begin
    op_a   = '0;
    op_x   = '0;
    op_sub = 1'b0;
    case (state)
      S_PRE: begin
        op_a = A_W'(xin_ch);
        op_x = $signed(SIG_W'(preamp_gain));
      end
      S_TERM_MUL: begin
        op_a   = A_W'(coef_q);
        op_x   = (term == 3'd0) ? s : hist_v;
        op_sub = (term >= 3'd3);
      end
      S_SM1: begin
        op_a = A_W'($signed({1'b0, csel}));
        op_x = $signed(SIG_W'(gain));
      end
      S_SM2: begin
        op_a = A_W'($signed({1'b0, cmpl}));
        op_x = $signed(SIG_W'(target));
      end
      S_OUT: begin
        op_a = A_W'(smp_ch);
        op_x = $signed(SIG_W'(gain));
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // one digit pass of the shared multiply-accumulate
  always_comb begin
    case (dig)
      2'd0:    dsel = $signed({1'b0, op_x[15:0]});
      2'd1:    dsel = $signed({1'b0, op_x[31:16]});
      default: dsel = $signed({op_x[47], op_x[47:32]});
    endcase
    prod    = op_a * dsel;
    shifted = ACC_W'(prod) <<< {dig, 4'd0};
    acc_sum = op_sub ? (acc - shifted) : (acc + shifted);
  end

  // biquad result, rounded sum scaled down and saturated to 48 bits
  always_comb begin
    bq_shr = acc >>> CFRAC;
    bq_top = bq_shr[ACC_W-1:SIG_W-1];
    if ((&bq_top) || !(|bq_top)) begin
      bq_sat = bq_shr[SIG_W-1:0];
    end else if (bq_shr[ACC_W-1]) begin
      bq_sat = {1'b1, {(SIG_W-1){1'b0}}};
    end else begin
      bq_sat = {1'b0, {(SIG_W-1){1'b1}}};
    end
  end

  // output scaling clamp
  always_comb begin
    out_shr = acc >>> 39;
    hi_lim  = wide_samples ? ACC_W'(24'sd8388607)  : ACC_W'(24'sd32767);
    lo_lim  = wide_samples ? ACC_W'(-25'sd8388608) : ACC_W'(-24'sd32768);
    if (out_shr > hi_lim) begin
      out_clamp = SMP_W'(hi_lim);
    end else if (out_shr < lo_lim) begin
      out_clamp = SMP_W'(lo_lim);
    end else begin
      out_clamp = SMP_W'(out_shr);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && command == CMD_FRAME) begin
          state_next = (active && nch_cfg != 2'd0) ? S_PRE : S_EMIT;
        end
      end
      S_PRE:      if (dig == 2'd2) state_next = S_PRE_END;
      S_PRE_END:  state_next = S_BAND_SEL;
      S_BAND_SEL: begin
        if (int'(band) == NUM_BANDS) begin
          state_next = S_CH_END;
        end else if (en_ext[5'(band)]) begin
          state_next = S_TERM_RD;
        end
      end
      S_TERM_RD:  state_next = S_TERM_MUL;
      S_TERM_MUL: begin
        if (dig == 2'd2) state_next = (term == 3'd4) ? S_BQ_END : S_TERM_RD;
      end
      S_BQ_END:   state_next = S_WB;
      S_WB:       if (wk == 2'd3) state_next = S_BAND_SEL;
      S_CH_END:   state_next = (!ch && nch == 2'd2) ? S_PRE : S_LIM;
      S_LIM:      state_next = (peak > ceil_q16) ? S_DIV : S_SM1;
      S_DIV:      if (int'(dcnt) == DIV_STEPS - 1) state_next = S_SM1;
      S_SM1:      if (dig == 2'd2) state_next = S_SM2;
      S_SM2:      if (dig == 2'd2) state_next = S_SM_END;
      S_SM_END:   state_next = S_OUT;
      S_OUT:      if (dig == 2'd2) state_next = S_OUT_END;
      S_OUT_END:  state_next = (!ch && nch == 2'd2) ? S_OUT : S_EMIT;
      S_EMIT:     if (emit_go) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // handshake and memory strobes
  always_comb begin
    in_stall = (state != S_IDLE);
    hist_we  = (state == S_WB);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass        <= 1'b0;
      band_enable   <= '0;
      preamp_gain   <= UNITY_PRE;
      atk_factor    <= '0;
      rel_factor    <= '0;
      wide_samples  <= 1'b0;
      channel_count <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BYPASS:   bypass        <= cfg_data[0];
        REG_BAND_EN:  band_enable   <= cfg_data[9:0];
        REG_PREAMP:   preamp_gain   <= cfg_data;
        REG_ATTACK:   atk_factor    <= cfg_data;
        REG_RELEASE:  rel_factor    <= cfg_data;
        REG_WIDE:     wide_samples  <= cfg_data[0];
        REG_CHANNELS: channel_count <= cfg_data[1:0];
        default:      ;
      endcase
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (in_acc && command == CMD_LOAD && coef_ok) begin
      coef_mem[coef_waddr] <= cv_scaled[COEFF_BITS-1:0];
    end
    if (state == S_TERM_RD) begin
      coef_q <= coef_mem[coef_raddr];
    end
  end

  // filter history memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (state == S_TERM_RD) begin
      hist_q <= hist_mem[hist_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_wide <= 1'b0;
      gain      <= UNITY_GAIN;
      hvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_acc && command == CMD_FRAME) begin
        if (active && wide_samples != last_wide) begin
          hvalid    <= '0;
          last_wide <= wide_samples;
        end
        if (!active) gain <= UNITY_GAIN;
      end
      if (hist_we) hvalid[hist_waddr] <= 1'b1;
      if (state == S_SM_END) gain <= acc[47:24];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        xin0 <= left_sample;
        xin1 <= right_sample;
        nch  <= nch_cfg;
        ch   <= 1'b0;
        dig  <= 2'd0;
        acc  <= ACC_W'(8);
        peak <= '0;
        ys0  <= left_sample;
        ys1  <= (nch_cfg == 2'd1) ? '0 : right_sample;
      end
      S_PRE: begin
        acc <= acc_sum;
        dig <= (dig == 2'd2) ? 2'd0 : dig + 2'd1;
      end
      S_PRE_END: begin
        s    <= SIG_W'(acc >>> 4);
        band <= '0;
      end
      S_BAND_SEL: begin
        term <= 3'd0;
        dig  <= 2'd0;
        acc  <= ACC_W'(1) <<< CFRAC - 1;
        if (int'(band) != NUM_BANDS && !en_ext[5'(band)]) band <= band + 1'b1;
      end
      S_TERM_RD: begin
        hv_q <= hvalid[hist_raddr];
        dig  <= 2'd0;
      end
      S_TERM_MUL: begin
        acc <= acc_sum;
        dig <= dig + 2'd1;
        if (dig == 2'd0 && term == 3'd1) h0_old <= hist_v;
        if (dig == 2'd0 && term == 3'd3) h2_old <= hist_v;
        if (dig == 2'd2) term <= term + 3'd1;
      end
      S_BQ_END: begin
        y  <= bq_sat;
        wk <= 2'd0;
      end
      S_WB: begin
        wk <= wk + 2'd1;
        if (wk == 2'd3) begin
          s    <= y;
          band <= band + 1'b1;
        end
      end
      S_CH_END: begin
        if (ch) smp1 <= s;
        else    smp0 <= s;
        if (s_abs > peak) peak <= s_abs;
        ch  <= 1'b1;
        dig <= 2'd0;
        acc <= ACC_W'(8);
      end
      S_LIM: begin
        rem    <= {(wide_samples ? CEIL_24 : CEIL_16), 39'd0};
        dsh    <= {peak, 23'd0};
        dcnt   <= '0;
        quo    <= '0;
        target <= UNITY_GAIN;
        dig    <= 2'd0;
        acc    <= ACC_W'(24'd8388608);
      end
      S_DIV: begin
        if (div_geq) rem <= rem - dsh[61:0];
        dsh  <= dsh >> 1;
        quo  <= {quo[22:0], div_geq};
        dcnt <= dcnt + 5'd1;
        if (int'(dcnt) == DIV_STEPS - 1) target <= {quo[22:0], div_geq};
      end
      S_SM1, S_SM2: begin
        acc <= acc_sum;
        dig <= (dig == 2'd2) ? 2'd0 : dig + 2'd1;
      end
      S_SM_END: begin
        ch  <= 1'b0;
        dig <= 2'd0;
        acc <= smp0[SIG_W-1] ? ACC_W'(40'h7FFFFFFFFF) : '0;
        ys1 <= '0;
      end
      S_OUT: begin
        acc <= acc_sum;
        dig <= (dig == 2'd2) ? 2'd0 : dig + 2'd1;
      end
      S_OUT_END: begin
        if (ch) ys1 <= out_clamp;
        else    ys0 <= out_clamp;
        ch  <= 1'b1;
        dig <= 2'd0;
        acc <= smp1[SIG_W-1] ? ACC_W'(40'h7FFFFFFFFF) : '0;
      end
      S_EMIT: begin
        if (emit_go) begin
          left_out  <= ys0;
          right_out <= ys1;
          gain_now  <= gain;
        end
      end
      default: begin
        dig <= 2'd0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // history is only rewritten for a band that is switched on
  a_wb_enabled: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> en_ext[5'(band)])
    else $error("history write for a disabled band");

  // limiter gain never rises above unity
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain_now <= UNITY_GAIN)
    else $error("limiter gain above unity");

  // divider never runs past its step count
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> int'(dcnt) < DIV_STEPS)
    else $error("divider step count overrun");

  // reset leaves unity gain and empty history
  a_reset_state: assert property (@(posedge clk)
    rst |=> (gain == UNITY_GAIN && hvalid == '0 && state == S_IDLE))
    else $error("reset state wrong");
`endif

endmodule
`default_nettype wire

// ===== sim/biquad_cascade_eq_limiter_top_test.sv =====
// Self-checking testbench for the biquad cascade equalizer with peak limiter.
// Needs bqeq_pkg and biquad_cascade_eq_limiter_top; a bit-exact predictor or a given expectation checks every frame.
`timescale 1ns / 100ps
module biquad_cascade_eq_limiter_top_test;
  import bqeq_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic               cmd;
    logic signed [23:0] l;
    logic signed [23:0] r;
    logic [3:0]         band;
    logic [2:0]         slot;
    logic signed [31:0] val;
  } frame_in_t;

  typedef struct {
    logic signed [23:0] l;
    logic signed [23:0] r;
    logic [23:0]        g;
  } frame_out_t;

  typedef struct {
    bit         is_cfg;
    cfg_reg_t   idx;
    int unsigned cv;
    frame_in_t  it;
    bit         typed;
    frame_out_t want;
  } dir_row_t;

  localparam wide_t SIG_MAX = (128'sd1 <<< 47) - 128'sd1;
  localparam wide_t SIG_MIN = -(128'sd1 <<< 47);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_FRAME;
  logic signed [23:0] left_sample = '0;
  logic signed [23:0] right_sample = '0;
  logic [3:0] coeff_band = '0;
  logic [2:0] coeff_slot = '0;
  logic signed [31:0] coeff_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;
  logic [23:0] gain_now;

  always #5 clk = ~clk;

  biquad_cascade_eq_limiter_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .left_sample(left_sample), .right_sample(right_sample),
    .coeff_band(coeff_band), .coeff_slot(coeff_slot), .coeff_value(coeff_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_out(left_out), .right_out(right_out), .gain_now(gain_now)
  );

  // Predictor state and register copies
  logic signed [31:0] coef_mem [50];
  logic signed [47:0] eq_hist [10][2][4];
  logic [23:0] lim_gain = UNITY_GAIN;
  logic hist_wide = 1'b0;
  logic        r_bypass = 1'b0;
  logic [9:0]  r_bands = '0;
  logic [23:0] r_pre = UNITY_PRE;
  logic [23:0] r_attack = '0;
  logic [23:0] r_release = '0;
  logic        r_wide = 1'b0;
  logic [1:0]  r_chan = 2'd2;

  frame_out_t expected_frames[$];
  int fail_count = 0;
  bit calm = 1'b0;

  function automatic wide_t sat_sig(wide_t v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  // One Direct Form I section, updates its history
  function automatic wide_t run_band(int b, int ch, wide_t x0);
    wide_t cb[5];
    wide_t acc;
    wide_t y0;
    for (int k = 0; k < 5; k++) cb[k] = coef_mem[b*5+k];
    acc = cb[0]*x0 + cb[1]*wide_t'(eq_hist[b][ch][0]) + cb[2]*wide_t'(eq_hist[b][ch][1])
        - cb[3]*wide_t'(eq_hist[b][ch][2]) - cb[4]*wide_t'(eq_hist[b][ch][3])
        + (128'sd1 <<< 27);
    y0 = sat_sig(acc >>> 28);
    eq_hist[b][ch][1] = eq_hist[b][ch][0];
    eq_hist[b][ch][0] = x0[47:0];
    eq_hist[b][ch][3] = eq_hist[b][ch][2];
    eq_hist[b][ch][2] = y0[47:0];
    return y0;
  endfunction

  // Frame: preamp, cascade, linked limiter, clamp
  function automatic frame_out_t eq_frame(logic signed [23:0] xl, logic signed [23:0] xr);
    frame_out_t res;
    wide_t xs[2];
    wide_t smp[2];
    wide_t s, peak, p, v, hi_lim, lo_lim, pre_s, g_s;
    longint unsigned ceil_v, target, c, g;
    int nch;
    bit act;
    xs[0] = xl;
    xs[1] = xr;
    res.l = xl;
    res.r = '0;
    nch = (r_chan > 2) ? 2 : r_chan;
    act = !r_bypass && (r_bands != 0 || r_pre != UNITY_PRE);
    if (act && r_wide != hist_wide) begin
      foreach (eq_hist[b, ch, k]) eq_hist[b][ch][k] = '0;
      hist_wide = r_wide;
    end
    if (!act || nch == 0) begin
      if (!act) lim_gain = UNITY_GAIN;
      res.r = (nch == 1) ? 24'sd0 : xr;
    end else begin
      peak = 0;
      smp[0] = 0;
      smp[1] = 0;
      pre_s = {104'd0, r_pre};
      for (int ch = 0; ch < nch; ch++) begin
        s = sat_sig((xs[ch] * pre_s + 128'sd8) >>> 4);
        for (int b = 0; b < 10; b++)
          if (r_bands[b]) s = run_band(b, ch, s);
        smp[ch] = s;
        if (s < 0) s = -s;
        if (s > peak) peak = s;
      end
      ceil_v = r_wide ? 64'(CEIL_24) : 64'(CEIL_16);
      hi_lim = r_wide ? 128'sd8388607 : 128'sd32767;
      lo_lim = r_wide ? -128'sd8388608 : -128'sd32768;
      target = UNITY_GAIN;
      if (peak > wide_t'(ceil_v << 16)) target = (ceil_v << 39) / 64'(peak);
      c = (target < 64'(lim_gain)) ? 64'(r_attack) : 64'(r_release);
      g = (c * lim_gain + ((64'd1 << 24) - c) * target + (64'd1 << 23)) >> 24;
      lim_gain = g[23:0];
      g_s = {104'd0, lim_gain};
      for (int ch = 0; ch < nch; ch++) begin
        p = smp[ch] * g_s;
        if (smp[ch] < 0) p = p + ((128'sd1 <<< 39) - 128'sd1);
        v = sat_sig(p >>> 39);
        if (v > hi_lim) v = hi_lim;
        if (v < lo_lim) v = lo_lim;
        if (ch == 0) res.l = v[23:0];
        else res.r = v[23:0];
      end
    end
    res.g = lim_gain;
    return res;
  endfunction

  // Output side: random stall after each transfer, compare with oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    frame_out_t w;
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result transfer with no frame pending");
        fail_count++;
      end else begin
        w = expected_frames.pop_front();
        if (left_out !== w.l) begin
          $error("left_out: expected %0d, got %0d", w.l, left_out);
          fail_count++;
        end
        if (right_out !== w.r) begin
          $error("right_out: expected %0d, got %0d", w.r, right_out);
          fail_count++;
        end
        if (gain_now !== w.g) begin
          $error("gain_now: expected %0d, got %0d", w.g, gain_now);
          fail_count++;
        end
      end
      n = calm ? 0 : $urandom_range(0, 5);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  // Wait until every result is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BYPASS:   r_bypass = v[0];
      REG_BAND_EN:  r_bands = v[9:0];
      REG_PREAMP:   r_pre = v[23:0];
      REG_ATTACK:   r_attack = v[23:0];
      REG_RELEASE:  r_release = v[23:0];
      REG_WIDE:     r_wide = v[0];
      REG_CHANNELS: r_chan = v[1:0];
      default: ;
    endcase
  endtask

  // One input transfer; the predictor runs at acceptance
  task automatic send(frame_in_t it, bit typed, frame_out_t want);
    int gap;
    frame_out_t got;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= it.cmd;
    left_sample <= it.l;
    right_sample <= it.r;
    coeff_band <= it.band;
    coeff_slot <= it.slot;
    coeff_value <= it.val;
    do @(posedge clk); while (in_stall);
    if (it.cmd == CMD_LOAD) begin
      if (it.band < 10 && it.slot < 5) coef_mem[it.band*5 + it.slot] = it.val;
    end else begin
      got = eq_frame(it.l, it.r);
      expected_frames.push_back(typed ? want : got);
    end
  endtask

  function automatic frame_in_t mk_frame(int l, int r);
    frame_in_t it;
    it = '{CMD_FRAME, l[23:0], r[23:0], 4'd0, 3'd0, 32'sd0};
    return it;
  endfunction

  function automatic frame_in_t mk_load(int band, int slot, int val);
    frame_in_t it;
    it = '{CMD_LOAD, 24'($urandom()), 24'($urandom()), band[3:0], slot[2:0], val};
    return it;
  endfunction

  // Well-behaved coefficient: b0 near unity, poles kept small
  function automatic int gentle_coef(int slot);
    int span;
    span = (slot >= 3) ? (1 << 25) : (1 << 26);
    return ((slot == 0) ? (1 << 28) : 0) + $urandom_range(0, 2*span) - span;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return int'($signed($urandom() << 8)) >>> 8;
    endcase
  endfunction

  dir_row_t dir_rows[$];

  function automatic dir_row_t cfg_row(cfg_reg_t idx, int unsigned v);
    dir_row_t d;
    d.is_cfg = 1'b1;
    d.idx = idx;
    d.cv = v;
    d.it = mk_frame(0, 0);
    d.typed = 1'b0;
    d.want = '{24'sd0, 24'sd0, 24'd0};
    return d;
  endfunction

  function automatic dir_row_t item_row(frame_in_t it, bit typed, int l, int r, int g);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.idx = REG_BYPASS;
    d.cv = 0;
    d.it = it;
    d.typed = typed;
    d.want = '{l[23:0], r[23:0], g[23:0]};
    return d;
  endfunction

  // Stimulus
  initial begin
    frame_in_t it;
    frame_out_t none;
    int sel;
    none = '{24'sd0, 24'sd0, 24'd0};
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (eq_hist[b, ch, k]) eq_hist[b][ch][k] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle after reset, bad loads, bypass, extremes, channel modes
    dir_rows.push_back(item_row(mk_frame(8388607, -8388608), 1, 8388607, -8388608, 8388608));
    dir_rows.push_back(item_row(mk_frame(0, -1), 1, 0, -1, 8388608));
    dir_rows.push_back(item_row(mk_load(15, 0, 32'h7fffffff), 0, 0, 0, 0));
    dir_rows.push_back(item_row(mk_load(3, 7, 32'h80000000), 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_BYPASS, 1));
    dir_rows.push_back(cfg_row(REG_PREAMP, 24'hffffff));
    dir_rows.push_back(item_row(mk_frame(123, -456), 1, 123, -456, 8388608));
    dir_rows.push_back(cfg_row(REG_BYPASS, 0));
    dir_rows.push_back(item_row(mk_frame(8388607, -8388608), 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_ATTACK, 24'hffffff));
    dir_rows.push_back(item_row(mk_frame(-8388608, 8388607), 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_CHANNELS, 1));
    dir_rows.push_back(item_row(mk_frame(30000, 77), 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_CHANNELS, 0));
    dir_rows.push_back(item_row(mk_frame(5, 6), 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_CHANNELS, 3));
    dir_rows.push_back(cfg_row(REG_WIDE, 1));
    dir_rows.push_back(cfg_row(REG_BAND_EN, 10'h3ff));
    dir_rows.push_back(item_row(mk_frame(8388607, 1), 0, 0, 0, 0));
    dir_rows.push_back(item_row(mk_load(9, 0, 32'h80000000), 0, 0, 0, 0));
    dir_rows.push_back(item_row(mk_frame(-4000000, 4000000), 0, 0, 0, 0));
    dir_rows.push_back(item_row(mk_load(9, 0, 32'h7fffffff), 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_PREAMP, 0));
    dir_rows.push_back(item_row(mk_frame(8388607, -8388608), 0, 0, 0, 0));

    // Every coefficient word is written before any band is enabled
    for (int b = 0; b < 10; b++)
      for (int s = 0; s < 5; s++)
        send(mk_load(b, s, gentle_coef(s)), 0, none);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].cv);
      else send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each with a fresh register setting
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_BYPASS, (ph == 3) ? 1 : 0);
      write_reg(REG_BAND_EN, (ph == 0) ? 10'h3ff : (ph == 1) ? 0 : $urandom_range(0, 1023));
      case (ph % 4)
        0: sel = UNITY_PRE;
        1: sel = (ph == 1) ? 24'hffffff : 0;
        default: sel = $urandom_range(100000, 3000000);
      endcase
      write_reg(REG_PREAMP, sel);
      write_reg(REG_ATTACK, (ph == 2) ? 0 : (ph == 4) ? 24'hffffff : $urandom_range(0, 24'hffffff));
      write_reg(REG_RELEASE, (ph == 4) ? 0 : (ph == 2) ? 24'hffffff
                                                      : $urandom_range(0, 24'hffffff));
      write_reg(REG_WIDE, $urandom_range(0, 1));
      case (ph)
        2: sel = 1;
        5: sel = 0;
        6: sel = 3;
        default: sel = 2;
      endcase
      write_reg(REG_CHANNELS, sel);
      calm = (ph == 5);
      for (int n = 0; n < 90; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8)
          it = mk_load($urandom_range(0, 9), $urandom_range(0, 4), gentle_coef($urandom_range(0, 4)));
        else if (sel < 11)
          it = mk_load($urandom_range(0, 9), $urandom_range(0, 4), $urandom());
        else if (sel < 14)
          it = mk_load($urandom_range(0, 15), $urandom_range(5, 7), $urandom());
        else if (sel < 15)
          it = mk_load($urandom_range(10, 15), $urandom_range(0, 7), $urandom());
        else
          it = mk_frame(rand_sample(), rand_sample());
        send(it, 0, none);
      end
      calm = 1'b0;
    end

    settle();
    repeat (700) @(posedge clk);
    if (fail_count == 0 && expected_frames.size() == 0)
      $display("biquad_cascade_eq_limiter_top_test: PASS");
    else
      $display("biquad_cascade_eq_limiter_top_test: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("biquad_cascade_eq_limiter_top_test: FAIL");
    $finish;
  end

endmodule
